@@ rtl/vie_pkg.sv @@
// ----------------------------------------------------------------------------
// vie_pkg
// shared widths, register indexes, reset values and match progress codes
// for the vendor element locator
// ----------------------------------------------------------------------------
package vie_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 4096;

  localparam int BYTE_W       = 8;
  localparam int CFG_DATA_W   = 24;
  localparam int CFG_INDEX_W  = 2;
  localparam int PAY_OFF_W    = 12;
  localparam int PAY_LEN_W    = 8;
  localparam int OUT_DATA_W   = 24;
  localparam int PROG_W       = 3;

  localparam logic [PAY_OFF_W-1:0] PAY_OFF_MAX = {PAY_OFF_W{1'b1}};

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FIRST_OFFSET = 2'd0,
    REG_ELEMENT_ID   = 2'd1,
    REG_OUI          = 2'd2,
    REG_VENDOR_TYPE  = 2'd3
  } cfg_reg_t;

  localparam logic [7:0]  FIRST_OFFSET_RST = 8'd36;
  localparam logic [7:0]  ELEMENT_ID_RST   = 8'hDD;
  localparam logic [23:0] OUI_RST          = 24'hFA0BBC;
  localparam logic [7:0]  VENDOR_TYPE_RST  = 8'h0D;

  localparam logic [7:0]  MIN_ELEMENT_LEN  = 8'd4;

  // match progress: idle, candidate with k-1 body bytes matched, matched
  localparam logic [PROG_W-1:0] PROG_IDLE  = 3'd0;
  localparam logic [PROG_W-1:0] PROG_OUI0  = 3'd1;
  localparam logic [PROG_W-1:0] PROG_OUI1  = 3'd2;
  localparam logic [PROG_W-1:0] PROG_OUI2  = 3'd3;
  localparam logic [PROG_W-1:0] PROG_TYPE  = 3'd4;
  localparam logic [PROG_W-1:0] PROG_DONE  = 3'd5;

  typedef struct packed {
    logic                 found;
    logic [PAY_OFF_W-1:0] payload_offset;
    logic [PAY_LEN_W-1:0] payload_length;
  } result_t;

endpackage

@@ rtl/vendor_ie_locator.sv @@
// output: the result is formed as the last byte is accepted and is registered on m_axis or in the skid entry
// throughput: one frame byte per cycle while the skid entry is empty, one result per frame
// the two-entry output buffer lets bytes flow while a result waits
// reset (rst, synchronous): registers back to defaults, walker cleared, buffer empty
// ----------------------------------------------------------------------------
// vendor_ie_locator
// walks the element list of a management frame byte by byte and reports the
// first vendor element that matches the configured id, oui and type
// ----------------------------------------------------------------------------
module vendor_ie_locator #(
  parameter int MAX_FRAME_BYTES = vie_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [vie_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [vie_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [vie_pkg::BYTE_W-1:0]        s_axis_tdata,   // [7:0] frame_byte
  input  logic                              s_axis_tlast,   // last_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [vie_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [11:0] payload_offset,
                                                            // [19:12] payload_length
  output logic                              m_axis_tuser    // found
);
  import vie_pkg::*;

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int NES_W = $clog2(MAX_FRAME_BYTES + 257);
  localparam int CMP_W = (POS_W > PAY_OFF_W) ? POS_W : PAY_OFF_W;

  // configuration
  logic [7:0]  first_offset;
  logic [7:0]  element_id;
  logic [23:0] oui;
  logic [7:0]  vendor_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_offset <= FIRST_OFFSET_RST;
      element_id   <= ELEMENT_ID_RST;
      oui          <= OUI_RST;
      vendor_type  <= VENDOR_TYPE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FIRST_OFFSET: first_offset <= cfg_data[7:0];
        REG_ELEMENT_ID:   element_id   <= cfg_data[7:0];
        REG_OUI:          oui          <= cfg_data;
        REG_VENDOR_TYPE:  vendor_type  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // walker state
  logic [POS_W-1:0]     byte_position, byte_position_next;
  logic [NES_W-1:0]     next_start, next_start_next;
  logic [7:0]           cur_id, cur_id_next;
  logic [7:0]           cur_len, cur_len_next;
  logic [PROG_W-1:0]    progress, progress_next;
  logic                 match_seen, match_seen_next;
  logic [POS_W-1:0]     match_offset, match_offset_next;
  logic [PAY_LEN_W-1:0] match_length, match_length_next;
  logic [NES_W-1:0]     match_end, match_end_next;

  logic             s_accept;
  logic             in_range;
  logic [7:0]       b;
  logic [NES_W-1:0] pos_w;
  logic [NES_W-1:0] start_cur;
  logic [7:0]       expected;
  logic             ok;
  logic [CMP_W-1:0] off_ext;
  result_t          result;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign b        = s_axis_tdata;
  assign in_range = byte_position < POS_W'(MAX_FRAME_BYTES);
  assign pos_w    = NES_W'(byte_position);

  always_comb begin
    unique case (progress)
      PROG_OUI0: expected = oui[23:16];
      PROG_OUI1: expected = oui[15:8];
      PROG_OUI2: expected = oui[7:0];
      default:   expected = vendor_type;
    endcase
  end

  always_comb begin
    byte_position_next = byte_position;
    next_start_next    = next_start;
    cur_id_next        = cur_id;
    cur_len_next       = cur_len;
    progress_next      = progress;
    match_seen_next    = match_seen;
    match_offset_next  = match_offset;
    match_length_next  = match_length;
    match_end_next     = match_end;
    start_cur          = (byte_position == '0) ? NES_W'(first_offset) : next_start;

    if (in_range) begin
      byte_position_next = byte_position + POS_W'(1);
      next_start_next    = start_cur;
      if (!match_seen) begin
        priority if (pos_w == start_cur) begin
          cur_id_next   = b;
          progress_next = PROG_IDLE;
        end else if (pos_w == start_cur + NES_W'(1)) begin
          cur_len_next    = b;
          next_start_next = pos_w + NES_W'(1) + NES_W'(b);
          progress_next   = (cur_id == element_id && b >= MIN_ELEMENT_LEN) ?
                            PROG_OUI0 : PROG_IDLE;
        end else if (progress >= PROG_OUI0 && progress <= PROG_TYPE) begin
          if (b == expected) begin
            progress_next = progress + PROG_W'(1);
            if (progress == PROG_TYPE) begin
              match_seen_next   = 1'b1;
              match_offset_next = byte_position + POS_W'(1);
              match_length_next = cur_len - MIN_ELEMENT_LEN;
              match_end_next    = next_start;
            end
          end else begin
            progress_next = PROG_IDLE;
          end
        end else begin
          progress_next = progress;
        end
      end
    end

    ok      = in_range && match_seen_next && (match_end_next <= pos_w + NES_W'(1));
    off_ext = CMP_W'(match_offset_next);
    result.found          = ok;
    result.payload_offset = '0;
    result.payload_length = '0;
    if (ok) begin
      result.payload_offset = (off_ext > CMP_W'(PAY_OFF_MAX)) ? PAY_OFF_MAX :
                              off_ext[PAY_OFF_W-1:0];
      result.payload_length = match_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s_accept && s_axis_tlast)) begin
      byte_position <= '0;
      next_start    <= '0;
      cur_id        <= '0;
      cur_len       <= '0;
      progress      <= PROG_IDLE;
      match_seen    <= 1'b0;
      match_offset  <= '0;
      match_length  <= '0;
      match_end     <= '0;
    end else if (s_accept) begin
      byte_position <= byte_position_next;
      next_start    <= next_start_next;
      cur_id        <= cur_id_next;
      cur_len       <= cur_len_next;
      progress      <= progress_next;
      match_seen    <= match_seen_next;
      match_offset  <= match_offset_next;
      match_length  <= match_length_next;
      match_end     <= match_end_next;
    end
  end

  // output register plus skid entry
  result_t out_q, skid_q;
  logic    out_valid, skid_valid;
  logic    push, pop;

  assign push          = s_accept && s_axis_tlast;
  assign pop           = out_valid && m_axis_tready;
  assign s_axis_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_q <= result;
      end else begin
        skid_q <= result;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_q.found;
  assign m_axis_tdata  = {(OUT_DATA_W - PAY_OFF_W - PAY_LEN_W)'(0),
                          out_q.payload_length, out_q.payload_offset};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_seen_is_done: assert property (@(posedge clk) disable iff (rst)
    match_seen |-> (progress == PROG_DONE))
    else $error("match flagged without full oui and type match");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (s_accept && !s_axis_tlast && in_range) |=>
      (byte_position == $past(byte_position) + POS_W'(1)))
    else $error("byte position did not advance");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_q.found) |-> (m_axis_tdata == '0))
    else $error("not-found result carries nonzero payload fields");

  a_end_after_offset: assert property (@(posedge clk) disable iff (rst)
    match_seen |-> (NES_W'(match_offset) <= match_end))
    else $error("matched element ends before its payload");

endmodule
